>>> hw/rtl/perfect_phylogeny_test_core_assert.svh
// Assertion macros for the perfect phylogeny test core
`ifndef PERFECT_PHYLOGENY_TEST_CORE_ASSERT_SVH
`define PERFECT_PHYLOGENY_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check with explicit clock and reset
`define PPT_ASSERT_CR(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check on the core's own clock and reset
`define PPT_ASSERT(lbl, prop, msg) \
   `PPT_ASSERT_CR(lbl, clock, reset, prop, msg)
`else
`define PPT_ASSERT_CR(lbl, clk, rst, prop, msg)
`define PPT_ASSERT(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/ppt_pkg.sv
// Shared constants, types and state encoding for the perfect phylogeny test core
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

   localparam int ROW_W    = 64;
   localparam int NC_W     = 7;
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 64;
   localparam int NC_RESET = 64;
   localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W    = $clog2(MAX_ROWS + 1);
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_KEY_RD,
      S_KEY_SH,
      S_SORT,
      S_CHK_RD,
      S_CHK_PERM,
      S_CHK_UPD,
      S_EM_RD,
      S_EM_PERM,
      S_EM_OUT
   } ppt_state_type;

   typedef struct packed {
      logic              load;
      logic              key_clear;
      logic              key_shift;
      logic              sort_step;
      logic              perm_load;
      logic              col_update;
      logic              out_load;
      logic              clear;
      logic              final_row;
      logic [ROW_AW-1:0] ridx;
      logic [COL_W-1:0]  phase;
   } ppt_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
   } ppt_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ppt_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module ppt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/ppt_ctrl.sv
// Sequencer for load, key build, sort, check and emit phases
`timescale 1ns / 1ps
`default_nettype none

module ppt_ctrl
   import ppt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last_row,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire ppt_status_type status,
   output ppt_cmd_type         cmd
);

   ppt_state_type     state_ff, state_in;
   logic [ROW_AW-1:0] ridx_ff, ridx_in;
   logic [COL_W-1:0]  phase_ff, phase_in;
   logic              accept;
   logic              at_last;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign at_last = ((CNT_W'(ridx_ff) + CNT_W'(1)) == status.cnt);

   // next state and cursors
   always_comb begin
      state_in = state_ff;
      ridx_in  = ridx_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_last_row) begin
               state_in = S_KEY_RD;
               ridx_in  = '0;
            end
         end
         S_KEY_RD: state_in = S_KEY_SH;
         S_KEY_SH: begin
            if (at_last) begin
               state_in = S_SORT;
               ridx_in  = '0;
               phase_in = '0;
            end else begin
               state_in = S_KEY_RD;
               ridx_in  = ridx_ff + ROW_AW'(1);
            end
         end
         S_SORT: begin
            if (phase_ff == COL_W'(MAX_COLS - 1)) begin
               state_in = S_CHK_RD;
            end else begin
               phase_in = phase_ff + COL_W'(1);
            end
         end
         S_CHK_RD:   state_in = S_CHK_PERM;
         S_CHK_PERM: state_in = S_CHK_UPD;
         S_CHK_UPD: begin
            if (at_last) begin
               state_in = S_EM_RD;
               ridx_in  = '0;
            end else begin
               state_in = S_CHK_RD;
               ridx_in  = ridx_ff + ROW_AW'(1);
            end
         end
         S_EM_RD:   state_in = S_EM_PERM;
         S_EM_PERM: state_in = S_EM_OUT;
         S_EM_OUT: begin
            if (!rsp_stall) begin
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EM_RD;
                  ridx_in  = ridx_ff + ROW_AW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd           = '0;
      cmd.ridx      = ridx_ff;
      cmd.phase     = phase_ff;
      cmd.final_row = at_last;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall     = 1'b0;
            cmd.load      = accept;
            cmd.key_clear = accept && req_last_row;
         end
         S_KEY_RD:   ;
         S_KEY_SH:   cmd.key_shift = 1'b1;
         S_SORT:     cmd.sort_step = 1'b1;
         S_CHK_RD:   ;
         S_CHK_PERM: cmd.perm_load = 1'b1;
         S_CHK_UPD:  cmd.col_update = 1'b1;
         S_EM_RD:    ;
         S_EM_PERM:  cmd.out_load = 1'b1;
         S_EM_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = !rsp_stall && at_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ridx_ff  <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         ridx_ff  <= ridx_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ppt_dp.sv
// Datapath: row store, column keys, sort lanes, left-one check and result register
`timescale 1ns / 1ps
`default_nettype none

module ppt_dp
   import ppt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ppt_cmd_type       cmd,
   output ppt_status_type         status,
   input  wire logic [ROW_W-1:0]  req_row_bits,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [NC_W-1:0]   csr_num_cols,
   output logic      [ROW_W-1:0]  rsp_ordered_row,
   output logic                   rsp_good,
   output logic                   rsp_overflow,
   output logic                   rsp_last
);

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [NC_W-1:0]     nc_ff;
   logic [NC_W-1:0]     nc_eff;
   logic                wr_en;
   logic [ROW_W-1:0]    rd_data;

   logic [MAX_ROWS-1:0] key_ff [MAX_COLS];
   logic [MAX_ROWS-1:0] key_in [MAX_COLS];
   logic                vld_ff [MAX_COLS];
   logic                vld_in [MAX_COLS];
   logic [COL_W-1:0]    ord_ff [MAX_COLS];
   logic [COL_W-1:0]    ord_in [MAX_COLS];

   logic [MAX_COLS-1:0] row_sel;
   logic [MAX_COLS-1:0] perm_c;
   logic [MAX_COLS-1:0] perm_ff;
   logic [NC_W-1:0]     lft    [MAX_COLS];
   logic                seen_ff [MAX_COLS];
   logic                seen_in [MAX_COLS];
   logic [NC_W-1:0]     fl_ff  [MAX_COLS];
   logic [NC_W-1:0]     fl_in  [MAX_COLS];
   logic                bad_ff, bad_in;

   assign status.cnt = cnt_ff;

   // column count clamp
   always_comb begin
      if (nc_ff == '0) begin
         nc_eff = NC_W'(1);
      end else if (nc_ff > NC_W'(MAX_COLS)) begin
         nc_eff = NC_W'(MAX_COLS);
      end else begin
         nc_eff = nc_ff;
      end
   end

   // row store
   assign wr_en = cmd.load && (cnt_ff < CNT_W'(MAX_ROWS));

   ppt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ROWS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ROW_AW-1:0]),
      .wr_data (req_row_bits),
      .rd_addr (cmd.ridx),
      .rd_data (rd_data)
   );

   // row count and overflow
   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.load) begin
         if (wr_en) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // key build and odd-even transposition sort, descending key
   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) begin
         key_in[i] = key_ff[i];
         vld_in[i] = vld_ff[i];
         ord_in[i] = ord_ff[i];
      end
      if (cmd.key_clear) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            key_in[i] = '0;
            vld_in[i] = (NC_W'(i) < nc_eff);
            ord_in[i] = COL_W'(i);
         end
      end else if (cmd.key_shift) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            key_in[i] = (key_ff[i] << 1) | MAX_ROWS'(rd_data[i]);
         end
      end else if (cmd.sort_step) begin
         for (int i = 0; i < MAX_COLS - 1; i++) begin
            if (((i & 1) == int'(cmd.phase[0])) &&
                ({vld_ff[i+1], key_ff[i+1]} > {vld_ff[i], key_ff[i]})) begin
               key_in[i]   = key_ff[i+1];
               key_in[i+1] = key_ff[i];
               vld_in[i]   = vld_ff[i+1];
               vld_in[i+1] = vld_ff[i];
               ord_in[i]   = ord_ff[i+1];
               ord_in[i+1] = ord_ff[i];
            end
         end
      end
   end

   // column permutation of the word read from the store
   assign row_sel = rd_data[MAX_COLS-1:0];
   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         perm_c[j] = (NC_W'(j) < nc_eff) ? row_sel[ord_ff[j]] : 1'b0;
      end
   end

   // position of nearest one to the left, as a prefix chain
   always_comb begin
      lft[0] = '0;
      for (int j = 1; j < MAX_COLS; j++) begin
         lft[j] = perm_ff[j-1] ? NC_W'(j) : lft[j-1];
      end
   end

   // every one cell of a column must share the same left position
   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         seen_in[j] = seen_ff[j];
         fl_in[j]   = fl_ff[j];
      end
      bad_in = bad_ff;
      if (cmd.key_clear) begin
         for (int j = 0; j < MAX_COLS; j++) begin
            seen_in[j] = 1'b0;
         end
         bad_in = 1'b0;
      end else if (cmd.col_update) begin
         for (int j = 0; j < MAX_COLS; j++) begin
            if (perm_ff[j]) begin
               if (!seen_ff[j]) begin
                  seen_in[j] = 1'b1;
                  fl_in[j]   = lft[j];
               end else if (fl_ff[j] != lft[j]) begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         nc_ff  <= NC_W'(NC_RESET);
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         if (csr_valid && csr_ready) begin
            nc_ff <= csr_num_cols;
         end
      end
   end

   // lanes, check state and result word
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_COLS; i++) begin
         key_ff[i]  <= key_in[i];
         vld_ff[i]  <= vld_in[i];
         ord_ff[i]  <= ord_in[i];
         seen_ff[i] <= seen_in[i];
         fl_ff[i]   <= fl_in[i];
      end
      bad_ff <= bad_in;
      if (cmd.perm_load) begin
         perm_ff <= perm_c;
      end
      if (cmd.out_load) begin
         rsp_ordered_row <= ROW_W'(perm_c);
         rsp_good        <= !bad_ff;
         rsp_overflow    <= ovf_ff;
         rsp_last        <= cmd.final_row;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/perfect_phylogeny_test_core.sv
// Top level of the perfect phylogeny test core
`timescale 1ns / 1ps
`default_nettype none

// Loads matrix rows one word per cycle while idle into a 32-entry row store;
// a row that arrives with the store full is dropped and flags overflow. The
// word marked last_row starts the test: the column keys are built by reading
// the store row by row, the columns are sorted by an odd-even transposition
// network of MAX_COLS lanes, every reordered row is checked for the left-one
// condition and then emitted with the good, overflow and last marks, each
// row held while rsp_stall is high. While the test runs, req_stall is high.
// csr_num_cols is always ready and must only be written while idle.

`include "perfect_phylogeny_test_core_assert.svh"

module perfect_phylogeny_test_core
   import ppt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ROW_W-1:0] req_row_bits,
   input  wire logic             req_last_row,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [ROW_W-1:0] rsp_ordered_row,
   output logic                  rsp_good,
   output logic                  rsp_overflow,
   output logic                  rsp_last,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [NC_W-1:0]  csr_num_cols
);

   ppt_cmd_type    cmd;
   ppt_status_type status;

   assign csr_ready = 1'b1;

   ppt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_last_row),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd)
   );

   ppt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_row_bits    (req_row_bits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_num_cols    (csr_num_cols),
      .rsp_ordered_row (rsp_ordered_row),
      .rsp_good        (rsp_good),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   // no input word is taken while a result is on offer
   `PPT_ASSERT(a_no_load_in_emit, rsp_valid |-> req_stall, "input open during emit")
   // after the final word is taken the core is idle again
   `PPT_ASSERT(a_idle_after_last, (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall, "not idle after last word")
   // row count stays within the store
   `PPT_ASSERT(a_cnt_bound, status.cnt <= CNT_W'(MAX_ROWS), "row count beyond store")

endmodule

`default_nettype wire
